>>> rtl/ils_pkg.sv
// Shared types and codes for the indexed list store.
package ils_pkg;

  localparam int TYPE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int TOTAL_W  = 36;

  // Request codes
  localparam logic [TYPE_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [TYPE_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [TYPE_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [TYPE_W-1:0] OP_READ    = 3'd3;
  localparam logic [TYPE_W-1:0] OP_REVERSE = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0]         req_type;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] entry_value;
  } ils_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_data;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;
    logic signed [TOTAL_W-1:0] total;
    logic signed [VALUE_W-1:0] largest;
  } ils_rsp_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD      = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_LOAD_READ = 3'd3,
    CMD_LOAD_MAX  = 3'd4,
    CMD_SWEEP     = 3'd5,
    CMD_PUSH      = 3'd6,
    CMD_COPY      = 3'd7
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

  // Where a cell stands relative to the request position and the fill level
  typedef struct packed {
    logic at_pos;
    logic above_pos;
    logic held;
  } cell_flags_t;

endpackage

>>> rtl/ils_cell.sv
// One list cell: stored entry plus a scan lane for reads, maximum and reversal.
module ils_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ils_pkg::cell_ctl_t                 ctl,
  input  ils_pkg::cell_flags_t               flags,
  input  logic signed [ils_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [ils_pkg::VALUE_W-1:0] right_entry,
  input  logic signed [ils_pkg::VALUE_W-1:0] left_aux,
  input  logic signed [ils_pkg::VALUE_W-1:0] right_aux,
  input  logic                               right_vld,
  output logic signed [ils_pkg::VALUE_W-1:0] entry,
  output logic signed [ils_pkg::VALUE_W-1:0] aux,
  output logic                               vld
);
  import ils_pkg::*;

  logic signed [VALUE_W-1:0] entry_r, entry_nxt;
  logic signed [VALUE_W-1:0] aux_r, aux_nxt;
  logic                      vld_r, vld_nxt;

  always_comb begin
    entry_nxt = entry_r;
    aux_nxt   = aux_r;
    vld_nxt   = vld_r;
    case (ctl.cmd)
      CMD_HOLD: begin
      end
      CMD_INSERT: begin
        if (flags.above_pos) begin
          entry_nxt = left_entry;
        end else if (flags.at_pos) begin
          entry_nxt = ctl.value;
        end
      end
      CMD_REMOVE: begin
        if (flags.at_pos || flags.above_pos) begin
          entry_nxt = right_entry;
        end
      end
      CMD_LOAD_READ: begin
        aux_nxt = entry_r;
        vld_nxt = flags.at_pos & flags.held;
      end
      CMD_LOAD_MAX: begin
        aux_nxt = entry_r;
        vld_nxt = flags.held;
      end
      CMD_SWEEP: begin
        // pull the better candidate down from the right neighbour
        if (right_vld && (!vld_r || (right_aux > aux_r))) begin
          aux_nxt = right_aux;
        end
        vld_nxt = vld_r | right_vld;
      end
      CMD_PUSH: begin
        entry_nxt = right_entry;
        aux_nxt   = left_aux;
      end
      CMD_COPY: begin
        entry_nxt = aux_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    aux_r   <= aux_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign entry = entry_r;
  assign aux   = aux_r;
  assign vld   = vld_r;

endmodule

>>> rtl/indexed_list_store_top.sv
// Top level of the indexed list store: request sequencer, cell chain and result register.
//
// Usage
//   in_valid/in_ready/in_word carry one request word: append, insert, remove,
//   read or reverse. out_valid/out_ready/out_word return exactly one result
//   word per request: read value, status, entry count, running total and the
//   largest held entry (zero when empty).
//   Requests are worked one at a time; in_ready is high whenever the
//   sequencer is idle, even while the previous result still waits in the
//   output register.
//   A new request is taken only once its predecessor's result has been loaded
//   into the output register. In the scan lane of the cell chain, a read
//   value and the largest entry both travel to cell 0 one cell per cycle.
//   After reset the list is empty, the total is zero and no result is
//   pending. When the receiver stalls, the finished result is held in the
//   output register and the sequencer waits before loading the next one.
module indexed_list_store_top #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ils_pkg::ils_req_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output ils_pkg::ils_rsp_t out_word
);
  import ils_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RLOAD  = 9'b000000010,
    S_RSWEEP = 9'b000000100,
    S_EXEC   = 9'b000001000,
    S_PUSH   = 9'b000010000,
    S_COPY   = 9'b000100000,
    S_MLOAD  = 9'b001000000,
    S_MSWEEP = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [TYPE_W-1:0]         op_r, op_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic signed [VALUE_W-1:0] rd_r, rd_nxt;
  logic signed [TOTAL_W-1:0] total_r, total_nxt;
  logic                      out_valid_r, out_valid_nxt;
  ils_rsp_t                  out_word_r, out_word_nxt;

  cell_ctl_t                 ctl;
  logic signed [VALUE_W-1:0] entry_w [CAPACITY];
  logic signed [VALUE_W-1:0] aux_w   [CAPACITY];
  logic                      vld_w   [CAPACITY];

  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic            full;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign pos_ext = CMPW'(in_word.position);
  assign cnt_ext = CMPW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    total_nxt     = total_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    ctl.cmd       = CMD_HOLD;
    ctl.value     = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_word.req_type;
          val_nxt    = in_word.entry_value;
          status_nxt = ST_OK;
          rd_nxt     = '0;
          pos_nxt    = CW'(in_word.position);
          state_nxt  = S_DONE;
          case (in_word.req_type)
            OP_APPEND: begin
              pos_nxt = count_r;
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            OP_INSERT: begin
              // position check ranks before the full check
              if (pos_ext > cnt_ext) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            OP_REMOVE, OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_RLOAD;
              end
            end
            OP_REVERSE: begin
              if (count_r >= CW'(2)) begin
                cnt_nxt   = count_r - CW'(1);
                state_nxt = S_PUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RLOAD: begin
        ctl.cmd   = CMD_LOAD_READ;
        cnt_nxt   = CW'(CAPACITY - 1);
        state_nxt = S_RSWEEP;
      end
      S_RSWEEP: begin
        ctl.cmd = CMD_SWEEP;
        if (cnt_r == '0) begin
          state_nxt = S_EXEC;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_EXEC: begin
        state_nxt = S_MLOAD;
        if ((op_r == OP_APPEND) || (op_r == OP_INSERT)) begin
          ctl.cmd   = CMD_INSERT;
          count_nxt = count_r + CW'(1);
          total_nxt = total_r + TOTAL_W'(val_r);
        end else if (op_r == OP_REMOVE) begin
          // cell 0's scan lane holds the entry being dropped
          ctl.cmd   = CMD_REMOVE;
          count_nxt = count_r - CW'(1);
          total_nxt = total_r - TOTAL_W'(aux_w[0]);
        end else begin
          rd_nxt = aux_w[0];
        end
      end
      S_PUSH: begin
        ctl.cmd = CMD_PUSH;
        if (cnt_r == '0) begin
          state_nxt = S_COPY;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_COPY: begin
        ctl.cmd   = CMD_COPY;
        state_nxt = S_MLOAD;
      end
      S_MLOAD: begin
        ctl.cmd   = CMD_LOAD_MAX;
        cnt_nxt   = CW'(CAPACITY - 1);
        state_nxt = S_MSWEEP;
      end
      S_MSWEEP: begin
        ctl.cmd = CMD_SWEEP;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_word_nxt.read_data   = rd_r;
          out_word_nxt.status      = status_r;
          out_word_nxt.entry_count = COUNT_W'(count_r);
          out_word_nxt.total       = total_r;
          out_word_nxt.largest     = vld_w[0] ? aux_w[0] : '0;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    pos_r      <= pos_nxt;
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    rd_r       <= rd_nxt;
    out_word_r <= out_word_nxt;
  end

  // Cell chain: cell 0 is the head of the list
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    cell_flags_t               flags;
    logic signed [VALUE_W-1:0] left_entry, right_entry, left_aux, right_aux;
    logic                      right_vld;

    assign flags.at_pos    = (IDX == pos_r);
    assign flags.above_pos = (IDX > pos_r);
    assign flags.held      = (IDX < count_r);

    if (i == 0) begin : g_head
      // the head pushes its own entry into the scan lane during a reverse
      assign left_entry = '0;
      assign left_aux   = entry_w[0];
    end else begin : g_body
      assign left_entry = entry_w[i-1];
      assign left_aux   = aux_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_aux   = '0;
      assign right_vld   = 1'b0;
    end else begin : g_inner
      assign right_entry = entry_w[i+1];
      assign right_aux   = aux_w[i+1];
      assign right_vld   = vld_w[i+1];
    end

    ils_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .flags       (flags),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .left_aux    (left_aux),
      .right_aux   (right_aux),
      .right_vld   (right_vld),
      .entry       (entry_w[i]),
      .aux         (aux_w[i]),
      .vld         (vld_w[i])
    );
  end

endmodule

>>> rtl/ils_checker.sv
// Port-level checks for the indexed list store, bound to the top level.
module ils_checker #(
  parameter int CAPACITY = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ils_pkg::ils_req_t in_word,
  input logic              out_valid,
  input logic              out_ready,
  input ils_pkg::ils_rsp_t out_word
);
  import ils_pkg::*;

  logic in_acc;
  assign in_acc = in_valid & in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_read_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != ST_OK) |-> out_word.read_data == '0)
    else $error("read data not zero on refused request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (CAPACITY < 32) && out_valid && (out_word.status == ST_FULL)
      |-> out_word.entry_count == COUNT_W'(CAPACITY))
    else $error("full status with list not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (CAPACITY < 32) && out_valid && (out_word.entry_count == '0)
      |-> (out_word.largest == '0) && (out_word.total == '0))
    else $error("empty list reports non-zero largest or total");

endmodule

bind indexed_list_store_top ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);

>>> tb/sv/tb.sv
// Self-checking testbench for the indexed list store: shadow list, random requests, paced handshakes.
`timescale 1ns / 1ps

module tb;
  import ils_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 7;
  // The slowest request is a read or remove; allow a margin.
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  // Request codes the block does not define; it must answer them and change nothing.
  localparam logic [TYPE_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [TYPE_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [TYPE_W-1:0] OP_SPARE_C = 3'd7;

  typedef enum int {
    MODE_FILL,
    MODE_EMPTY_OUT,
    MODE_MIX
  } load_mode_t;

  // Shadow of the list: slots below held are live, the rest are never looked at.
  typedef struct {
    logic signed [VALUE_W-1:0] slot [CAPACITY];
    int                        held;
    logic signed [TOTAL_W-1:0] sum;
  } list_state_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ils_req_t in_word   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ils_rsp_t out_word;

  ils_req_t    pending_words [$];
  ils_rsp_t    expected_results [$];
  list_state_t accepted_list;
  list_state_t planned_list;

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_requests  = 0;
  int         holds_served   = 0;
  int         stall_left     = 0;
  int         queued_items   = 0;
  int         mismatch_count = 0;
  int         burst_left     = 0;
  int         quiet_cycles   = 0;
  load_mode_t load_mode      = MODE_FILL;

  indexed_list_store_top #(
    .CAPACITY (CAPACITY)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Apply one request to a shadow list and return the word the block should answer with.
  // Position checks come before the full check, so a bad insert on a full list reports range.
  function automatic ils_rsp_t apply_request(ref list_state_t s, input ils_req_t r);
    ils_rsp_t                  o;
    int                        p;
    int                        i;
    logic signed [VALUE_W-1:0] t;
    o = '0;
    p = r.position;
    case (r.req_type)
      OP_APPEND: begin
        if (s.held >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          s.slot[s.held] = r.entry_value;
          s.held++;
          s.sum += r.entry_value;
        end
      end
      OP_INSERT: begin
        if (p > s.held) begin
          o.status = ST_RANGE;
        end else if (s.held >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          for (i = s.held; i > p; i--) s.slot[i] = s.slot[i-1];
          s.slot[p] = r.entry_value;
          s.held++;
          s.sum += r.entry_value;
        end
      end
      OP_REMOVE: begin
        if (p >= s.held) begin
          o.status = ST_RANGE;
        end else begin
          s.sum -= s.slot[p];
          for (i = p; i + 1 < s.held; i++) s.slot[i] = s.slot[i+1];
          s.held--;
        end
      end
      OP_READ: begin
        if (p >= s.held) begin
          o.status = ST_RANGE;
        end else begin
          o.read_data = s.slot[p];
        end
      end
      OP_REVERSE: begin
        for (i = 0; i < s.held / 2; i++) begin
          t = s.slot[i];
          s.slot[i] = s.slot[s.held-1-i];
          s.slot[s.held-1-i] = t;
        end
      end
      default: ;
    endcase
    o.entry_count = COUNT_W'(s.held);
    o.total       = s.sum;
    if (s.held > 0) begin
      o.largest = s.slot[0];
      for (i = 1; i < s.held; i++) begin
        if (s.slot[i] > o.largest) o.largest = s.slot[i];
      end
    end
    return o;
  endfunction

  // Queue one word for the driver. Track the planned list so that positions can be aimed
  // at live entries; every word counts towards the item budget.
  task automatic queue_word(input logic [TYPE_W-1:0] op, input int pos,
                            input logic [VALUE_W-1:0] value);
    ils_req_t r;
    r.req_type    = op;
    r.position    = POS_W'(pos);
    r.entry_value = value;
    void'(apply_request(planned_list, r));
    queued_items++;
    pending_words.push_back(r);
  endtask

  // Favour the extremes and small values that tie with each other for the largest entry.
  function automatic logic [VALUE_W-1:0] pick_value();
    int v;
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3: begin
        v = $urandom_range(16);
        return VALUE_W'(v - 8);
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_random();
    int                roll;
    int                pos;
    int                cnt;
    logic [TYPE_W-1:0] op;
    cnt  = planned_list.held;
    roll = $urandom_range(99);
    case (load_mode)
      MODE_FILL: begin
        if      (roll < 40) op = OP_APPEND;
        else if (roll < 75) op = OP_INSERT;
        else if (roll < 85) op = OP_READ;
        else if (roll < 92) op = OP_REMOVE;
        else if (roll < 97) op = OP_REVERSE;
        else                op = TYPE_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      end
      MODE_EMPTY_OUT: begin
        if      (roll < 10) op = OP_APPEND;
        else if (roll < 20) op = OP_INSERT;
        else if (roll < 35) op = OP_READ;
        else if (roll < 85) op = OP_REMOVE;
        else if (roll < 96) op = OP_REVERSE;
        else                op = TYPE_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      end
      default: begin
        if      (roll < 22) op = OP_APPEND;
        else if (roll < 44) op = OP_INSERT;
        else if (roll < 64) op = OP_READ;
        else if (roll < 84) op = OP_REMOVE;
        else if (roll < 96) op = OP_REVERSE;
        else                op = TYPE_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      end
    endcase
    // Aim most positions at live entries; the rest roam the whole field.
    if ($urandom_range(9) < 8) begin
      if (op == OP_INSERT)  pos = $urandom_range(cnt);
      else if (cnt > 0)     pos = $urandom_range(cnt - 1);
      else                  pos = 0;
    end else begin
      pos = $urandom_range((1 << POS_W) - 1);
    end
    queue_word(op, pos, pick_value());
  endtask

  // Hold off new words until the driver has nothing left and every answer is in.
  task automatic wait_for_drain();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random(input int send_pct, input int recv_pct, input int budget,
                            input bit long_hold);
    int start;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_requests++;
    start = queued_items;
    while (queued_items - start < budget) begin
      if (burst_left == 0) begin
        load_mode  = load_mode_t'($urandom_range(2));
        burst_left = $urandom_range(12, 40);
      end
      queue_random();
      burst_left--;
    end
    wait_for_drain();
  endtask

  // Stimulus: a directed opening, then random phases with different pacing on each side.
  initial begin
    planned_list.held = 0;
    planned_list.sum  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: every indexed request is out of range, reverse is a no-op.
    queue_word(OP_READ,    0, 32'h0000_0000);
    queue_word(OP_REVERSE, 0, 32'h0000_0000);
    queue_word(OP_REMOVE,  0, 32'h0000_0000);
    queue_word(OP_INSERT,  1, 32'h1234_5678);
    // Insert at index 0 into an empty list must be taken.
    queue_word(OP_INSERT,  0, 32'h8000_0000);
    queue_word(OP_APPEND,  0, 32'h7FFF_FFFF);
    queue_word(OP_APPEND, 31, 32'hFFFF_FFFF);
    // Insert at the fill level behaves as an append; then one in the middle.
    queue_word(OP_INSERT,  3, 32'h0000_0005);
    queue_word(OP_INSERT,  1, 32'h0000_0000);
    queue_word(OP_INSERT, 17, 32'h5555_5555);
    queue_word(OP_READ,    0, 32'hFFFF_FFFF);
    queue_word(OP_READ,    4, 32'h0000_0000);
    queue_word(OP_READ,    5, 32'h0000_0000);
    queue_word(OP_READ,   16, 32'h0000_0000);
    queue_word(OP_READ,   31, 32'h0000_0000);
    queue_word(OP_REVERSE, 0, 32'h0000_0000);
    queue_word(OP_READ,    0, 32'h0000_0000);
    queue_word(OP_REMOVE, 31, 32'h0000_0000);
    queue_word(OP_REMOVE,  4, 32'h0000_0000);
    queue_word(OP_REMOVE,  0, 32'h0000_0000);
    // Undefined codes with assorted positions and extreme values: no change, status ok.
    queue_word(OP_SPARE_A, 31, 32'hFFFF_FFFF);
    queue_word(OP_SPARE_B,  0, 32'h8000_0000);
    queue_word(OP_SPARE_C, 16, 32'h7FFF_FFFF);
    wait_for_drain();

    run_random( 0,  0, 210, 1'b0);
    run_random(54,  0, 210, 1'b0);
    run_random( 0, 54, 210, 1'b0);
    run_random(10, 10, 200, 1'b0);
    // Back-pressure: the receiver goes quiet while the sender keeps offering words.
    run_random( 0,  0,  60, 1'b1);
    run_random( 0,  0, 160, 1'b0);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Driver: predict at each accepted word, then offer the next one or idle.
  // Once valid is up it holds, with the same word, until the handshake.
  always @(posedge clk) begin
    bit still_offered;
    if (!rst_n) begin
      in_valid <= 1'b0;
      accepted_list.held = 0;
      accepted_list.sum  = '0;
    end else begin
      still_offered = in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(accepted_list, in_word));
        still_offered = 1'b0;
      end
      if (!still_offered) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result against the oldest prediction, drive out_ready.
  always @(posedge clk) begin
    ils_rsp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: result word with nothing expected: data %0d status %0d count %0d",
                     $realtime, out_word.read_data, out_word.status, out_word.entry_count);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_word.read_data   !== want.read_data   ||
              out_word.status      !== want.status      ||
              out_word.entry_count !== want.entry_count ||
              out_word.total       !== want.total       ||
              out_word.largest     !== want.largest) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: mismatch, expected data %0d status %0d count %0d total %0d max %0d",
                       $realtime, want.read_data, want.status, want.entry_count,
                       want.total, want.largest);
              $display("%0t:           actual   data %0d status %0d count %0d total %0d max %0d",
                       $realtime, out_word.read_data, out_word.status, out_word.entry_count,
                       out_word.total, out_word.largest);
            end
            mismatch_count++;
          end
        end
      end
      // A long hold-off, counted here; otherwise stall at the phase's rate.
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

>>> files.f
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store_top.sv
rtl/ils_checker.sv
tb/sv/tb.sv
